// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the bytecode store.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BCS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bcs assertion failed");

// next-cycle implication
`define BCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bcs assertion failed");

`endif

// ===== rtl/bcs_pkg.sv =====
// Package for the bytecode store: sizes, request and status codes,
// word types, controller states and controller/datapath interface structs.
package bcs_pkg;

  localparam int CODE_DEPTH = 4096;
  localparam int RUN_DEPTH  = 1024;
  localparam int CODE_AW    = $clog2(CODE_DEPTH);
  localparam int CNT_W      = CODE_AW + 1;
  localparam int RUN_AW     = $clog2(RUN_DEPTH);
  localparam int RUN_CW     = RUN_AW + 1;
  localparam int REQ_W      = 3;
  localparam int DATA_W     = 32;
  localparam int LINE_W     = 20;
  localparam int OFF_W      = 12;
  localparam int ST_W       = 3;
  localparam int CMP_W      = ((CNT_W > OFF_W) ? CNT_W : OFF_W) + 1;

  localparam logic [REQ_W-1:0] REQ_WR_BYTE = 3'd0;
  localparam logic [REQ_W-1:0] REQ_WR_WORD = 3'd1;
  localparam logic [REQ_W-1:0] REQ_RD_BYTE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_RD_WORD = 3'd3;
  localparam logic [REQ_W-1:0] REQ_LOOKUP  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd1;
  localparam logic [ST_W-1:0] ST_BACKWARDS = 3'd2;
  localparam logic [ST_W-1:0] ST_RANGE     = 3'd3;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [DATA_W-1:0] data_in;
    logic [LINE_W-1:0] src_line;
    logic [OFF_W-1:0]  offset_in;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [LINE_W-1:0] line_out;
    logic [ST_W-1:0]   status;
  } out_item_t;

  typedef struct packed {
    logic [LINE_W-1:0] line;
    logic [CNT_W-1:0]  bytes;
  } run_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_WR,
    S_RD,
    S_RD_LAST,
    S_LK_RD,
    S_LK_CHK,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic            load;
    logic            set_st;
    logic [ST_W-1:0] st_code;
    logic            wr_byte;
    logic            wr_run;
    logic            rd_issue;
    logic            lk_step;
    logic            lk_found;
  } dp_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             backwards;
    logic             full;
    logic             range_err;
    logic             no_runs;
    logic             cnt_last;
    logic             lk_hit;
    logic             lk_last;
  } dp_stat_t;

endpackage

// ===== rtl/bcs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bcs_ctrl.sv =====
// Controller state machine for the bytecode store.
// Depends on bcs_pkg; drives bcs_dp through dp_cmd_t and reads dp_stat_t.
module bcs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  bcs_pkg::dp_stat_t stat,
  output bcs_pkg::dp_cmd_t  cmd,
  output logic              busy,
  output logic              out_valid
);

  bcs_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bcs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    busy      = (state_r != bcs_pkg::S_IDLE);
    out_valid = 1'b0;
    case (state_r)
      bcs_pkg::S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = bcs_pkg::S_EVAL;
        end
      end
      bcs_pkg::S_EVAL: begin
        case (stat.req)
          bcs_pkg::REQ_WR_BYTE, bcs_pkg::REQ_WR_WORD: begin
            if (stat.backwards) begin
              cmd.set_st  = 1'b1;
              cmd.st_code = bcs_pkg::ST_BACKWARDS;
              state_nxt   = bcs_pkg::S_DONE;
            end else if (stat.full) begin
              cmd.set_st  = 1'b1;
              cmd.st_code = bcs_pkg::ST_FULL;
              state_nxt   = bcs_pkg::S_DONE;
            end else begin
              state_nxt = bcs_pkg::S_WR;
            end
          end
          bcs_pkg::REQ_RD_BYTE, bcs_pkg::REQ_RD_WORD: begin
            if (stat.range_err) begin
              cmd.set_st  = 1'b1;
              cmd.st_code = bcs_pkg::ST_RANGE;
              state_nxt   = bcs_pkg::S_DONE;
            end else begin
              state_nxt = bcs_pkg::S_RD;
            end
          end
          bcs_pkg::REQ_LOOKUP: begin
            if (stat.no_runs) begin
              cmd.set_st  = 1'b1;
              cmd.st_code = bcs_pkg::ST_NOT_FOUND;
              state_nxt   = bcs_pkg::S_DONE;
            end else begin
              state_nxt = bcs_pkg::S_LK_RD;
            end
          end
          default: begin
            state_nxt = bcs_pkg::S_DONE;
          end
        endcase
      end
      bcs_pkg::S_WR: begin
        cmd.wr_byte = 1'b1;
        if (stat.cnt_last) begin
          cmd.wr_run = 1'b1;
          state_nxt  = bcs_pkg::S_DONE;
        end
      end
      bcs_pkg::S_RD: begin
        cmd.rd_issue = 1'b1;
        if (stat.cnt_last) begin
          state_nxt = bcs_pkg::S_RD_LAST;
        end
      end
      bcs_pkg::S_RD_LAST: begin
        state_nxt = bcs_pkg::S_DONE;
      end
      bcs_pkg::S_LK_RD: begin
        state_nxt = bcs_pkg::S_LK_CHK;
      end
      bcs_pkg::S_LK_CHK: begin
        if (stat.lk_hit) begin
          cmd.lk_found = 1'b1;
          state_nxt    = bcs_pkg::S_DONE;
        end else if (stat.lk_last) begin
          cmd.set_st  = 1'b1;
          cmd.st_code = bcs_pkg::ST_NOT_FOUND;
          state_nxt   = bcs_pkg::S_DONE;
        end else begin
          cmd.lk_step = 1'b1;
          state_nxt   = bcs_pkg::S_LK_RD;
        end
      end
      bcs_pkg::S_DONE: begin
        out_valid = 1'b1;
        state_nxt = bcs_pkg::S_IDLE;
      end
      default: begin
        state_nxt = bcs_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/bcs_dp.sv =====
// Datapath for the bytecode store: byte RAM, run table RAM, fill counters,
// top-run registers, lookup walker and result registers.
// Depends on bcs_pkg and bcs_ram; commanded by bcs_ctrl.
module bcs_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  bcs_pkg::in_item_t  in_data,
  input  bcs_pkg::dp_cmd_t   cmd,
  output bcs_pkg::dp_stat_t  stat,
  output bcs_pkg::out_item_t out_data
);

  localparam int CNT_W  = bcs_pkg::CNT_W;
  localparam int RUN_CW = bcs_pkg::RUN_CW;
  localparam int RUN_AW = bcs_pkg::RUN_AW;
  localparam int CODE_AW = bcs_pkg::CODE_AW;
  localparam int CMP_W  = bcs_pkg::CMP_W;

  bcs_pkg::in_item_t  req_r;
  bcs_pkg::out_item_t res_r;
  bcs_pkg::run_entry_t run_wdata, run_rdata;

  logic [CNT_W-1:0]          byte_count_r;
  logic [RUN_CW-1:0]         run_count_r;
  logic [bcs_pkg::LINE_W-1:0] last_line_r;
  logic [CNT_W-1:0]          top_bytes_r;
  logic [1:0]                cnt_r;
  logic [1:0]                lane_r;
  logic                      rd_pend_r;
  logic [RUN_CW-1:0]         lk_idx_r;
  logic [CNT_W-1:0]          base_r;

  logic              is_word, extend;
  logic [CNT_W-1:0]  nbytes, free_bytes, lk_sum;
  logic [CMP_W-1:0]  off_ext, cnt_ext;
  logic              run_we;
  logic [RUN_AW-1:0] run_waddr;
  logic [CODE_AW-1:0] byte_raddr;
  logic [7:0]        byte_wdata, byte_rdata;

  assign is_word = (req_r.req_type == bcs_pkg::REQ_WR_WORD) ||
                   (req_r.req_type == bcs_pkg::REQ_RD_WORD);
  assign nbytes  = is_word ? CNT_W'(4) : CNT_W'(1);
  assign extend  = (run_count_r != '0) && (req_r.src_line == last_line_r);
  assign free_bytes = CNT_W'(bcs_pkg::CODE_DEPTH) - byte_count_r;
  assign off_ext = CMP_W'(req_r.offset_in);
  assign cnt_ext = CMP_W'(byte_count_r);
  assign lk_sum  = base_r + run_rdata.bytes;

  always_comb begin
    stat.req       = req_r.req_type;
    stat.backwards = (run_count_r != '0) && (req_r.src_line < last_line_r);
    stat.full      = (free_bytes < nbytes) ||
                     (!extend && (run_count_r == RUN_CW'(bcs_pkg::RUN_DEPTH)));
    stat.range_err = is_word ? ((off_ext + CMP_W'(4)) > cnt_ext) : (off_ext >= cnt_ext);
    stat.no_runs   = (run_count_r == '0);
    stat.cnt_last  = is_word ? (cnt_r == 2'd3) : (cnt_r == 2'd0);
    stat.lk_hit    = off_ext < CMP_W'(lk_sum);
    stat.lk_last   = (lk_idx_r + RUN_CW'(1)) == run_count_r;
  end

  // byte store
  assign byte_wdata = req_r.data_in[cnt_r*8 +: 8];
  assign byte_raddr = req_r.offset_in[CODE_AW-1:0] + CODE_AW'(cnt_r);

  bcs_ram #(
    .WIDTH(8),
    .DEPTH(bcs_pkg::CODE_DEPTH)
  ) u_byte_ram (
    .clk  (clk),
    .we   (cmd.wr_byte),
    .waddr(byte_count_r[CODE_AW-1:0]),
    .wdata(byte_wdata),
    .raddr(byte_raddr),
    .rdata(byte_rdata)
  );

  // run table
  assign run_we          = cmd.wr_run;
  assign run_waddr       = extend ? RUN_AW'(run_count_r - RUN_CW'(1)) : run_count_r[RUN_AW-1:0];
  assign run_wdata.line  = req_r.src_line;
  assign run_wdata.bytes = extend ? (top_bytes_r + nbytes) : nbytes;

  bcs_ram #(
    .WIDTH($bits(bcs_pkg::run_entry_t)),
    .DEPTH(bcs_pkg::RUN_DEPTH)
  ) u_run_ram (
    .clk  (clk),
    .we   (run_we),
    .waddr(run_waddr),
    .wdata(run_wdata),
    .raddr(lk_idx_r[RUN_AW-1:0]),
    .rdata(run_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      run_count_r  <= '0;
      rd_pend_r    <= 1'b0;
    end else begin
      rd_pend_r <= cmd.rd_issue;
      if (cmd.wr_byte) begin
        byte_count_r <= byte_count_r + CNT_W'(1);
      end
      if (cmd.wr_run && !extend) begin
        run_count_r <= run_count_r + RUN_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= cnt_r;
    if (cmd.load) begin
      req_r    <= in_data;
      res_r    <= '0;
      cnt_r    <= '0;
      lk_idx_r <= '0;
      base_r   <= '0;
    end else begin
      if (cmd.wr_byte || cmd.rd_issue) begin
        cnt_r <= cnt_r + 2'd1;
      end
      if (cmd.set_st) begin
        res_r.status <= cmd.st_code;
      end
      if (rd_pend_r) begin
        res_r.read_data[lane_r*8 +: 8] <= byte_rdata;
      end
      if (cmd.lk_found) begin
        res_r.line_out <= run_rdata.line;
      end
      if (cmd.lk_step) begin
        base_r   <= lk_sum;
        lk_idx_r <= lk_idx_r + RUN_CW'(1);
      end
    end
    if (cmd.wr_run) begin
      last_line_r <= req_r.src_line;
      top_bytes_r <= run_wdata.bytes;
    end
  end

  assign out_data = res_r;

endmodule

// ===== rtl/bytecode_store_with_line_runs.sv =====
// Top level of the append-only bytecode store with run-length line table.
// Depends on bcs_pkg, bcs_ctrl, bcs_dp and assert_macros.svh.
//
// A request is taken when start is high and busy is low; busy then stays high
// until the single result has been shown on out_data for one cycle with
// out_valid high, and a new request may start the cycle after. The receiver
// cannot stall. Each request is first evaluated; a byte or word write then
// stores one byte per cycle into the byte RAM, a byte or word read issues one
// byte read per cycle (read data registered), and a line lookup walks the run
// table with one run-table read per step, summing run lengths. A rejected
// request or unused code goes from S_EVAL straight to the result strobe.
// There is no clearing pass after reset.
module bytecode_store_with_line_runs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  bcs_pkg::in_item_t  in_data,
  output logic               out_valid,
  output bcs_pkg::out_item_t out_data
);

`include "assert_macros.svh"

  bcs_pkg::dp_cmd_t  cmd;
  bcs_pkg::dp_stat_t stat;

  bcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy),
    .out_valid(out_valid)
  );

  bcs_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .stat    (stat),
    .out_data(out_data)
  );

  `BCS_ASSERT_NOW(a_strobe_in_busy, out_valid, busy)
  `BCS_ASSERT_NEXT(a_idle_after_word, out_valid, !busy && !out_valid)
  `BCS_ASSERT_NEXT(a_no_early_word, start && !busy, busy && !out_valid)
  `BCS_ASSERT_NOW(a_fail_zero_data, out_valid && (out_data.status != bcs_pkg::ST_OK),
    out_data.read_data == '0)

endmodule
